// ----- sv/pht_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the pending handle table with time-to-live.
// No dependencies; imported by every module of the block.
package pht_pkg;

  typedef enum logic [2:0] {
    ACT_RECORD = 3'd0,
    ACT_CLAIM  = 3'd1,
    ACT_FORGET = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_COUNT  = 3'd4,
    ACT_TICK   = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_REPLACED = 3'd1,
    ST_EVICTED  = 3'd2,
    ST_REJECTED = 3'd3,
    ST_CLAIMED  = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_DONE     = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DONE
  } state_e;

  localparam int unsigned HandleW   = 64;
  localparam int unsigned AppW      = 32;
  localparam int unsigned AgeW      = 32;
  localparam int unsigned TtlW      = 32;
  localparam int unsigned CountOutW = 6;

  localparam logic [TtlW-1:0] TtlReset = 32'd60;

  typedef struct packed {
    logic               valid;
    logic [HandleW-1:0] handle;
    logic [AppW-1:0]    app;
    logic [AgeW-1:0]    age;
  } entry_t;

  // Per-cell controls for one clock cycle.
  typedef struct packed {
    logic shift;
    logic load;
    logic tick;
    logic clear;
    logic dec_en;
  } cell_ctl_t;

  // What the head unit does with the entry passing it.
  typedef struct packed {
    logic run;
    logic prune;
    logic lookup;
    logic replace;
  } head_ctl_t;

  // Head unit status back to the sequencer.
  typedef struct packed {
    logic dec_en;
    logic cnt_dec;
    logic found;
    logic free_v;
    logic best_v;
  } head_stat_t;

endpackage

// ----- sv/pht_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the entry ring: holds an entry and its insertion rank.
// Depends on pht_pkg for the entry and control types.
module pht_cell import pht_pkg::*; #(
  parameter int unsigned RankW = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  entry_t           nb_i,
  input  logic [RankW-1:0] nb_rank_i,
  input  entry_t           ld_i,
  input  logic [RankW-1:0] ld_rank_i,
  input  logic [RankW-1:0] dec_rank_i,
  output entry_t           entry_o,
  output logic [RankW-1:0] rank_o
);

  logic               valid_q, valid_d;
  logic [HandleW-1:0] handle_q;
  logic [AppW-1:0]    app_q;
  logic [AgeW-1:0]    age_q;
  logic [RankW-1:0]   rank_q, rank_d;
  entry_t             own, base, entry_d;
  logic [RankW-1:0]   base_rank;

  always_comb begin
    own       = '{valid: valid_q, handle: handle_q, app: app_q, age: age_q};
    base      = ctl_i.shift ? nb_i : own;
    base_rank = ctl_i.shift ? nb_rank_i : rank_q;
    entry_d   = base;
    rank_d    = base_rank;
    if (ctl_i.load) begin
      entry_d = ld_i;
      rank_d  = ld_rank_i;
    end else begin
      // A dropped entry below us in rank order closes the gap.
      if (ctl_i.dec_en && base.valid && (base_rank > dec_rank_i)) begin
        rank_d = base_rank - 1'b1;
      end
      if (ctl_i.tick && base.valid && (base.age != '1)) begin
        entry_d.age = base.age + 1'b1;
      end
      if (ctl_i.clear) begin
        entry_d.valid = 1'b0;
      end
    end
    valid_d = entry_d.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= entry_d.handle;
    app_q    <= entry_d.app;
    age_q    <= entry_d.age;
    rank_q   <= rank_d;
  end

  assign entry_o = own;
  assign rank_o  = rank_q;

endmodule

// ----- sv/pht_head.sv -----
`timescale 1ns / 1ps
// Head unit of the entry ring: prunes, looks up and tracks the eviction victim
// as each entry passes cell zero. Depends on pht_pkg.
module pht_head import pht_pkg::*; #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  head_ctl_t                        ctl_i,
  input  logic [HandleW-1:0]               key_i,
  input  logic [AppW-1:0]                  app_i,
  input  logic [TtlW-1:0]                  ttl_i,
  input  logic [$clog2(SLOTS+1)-1:0]       count_i,
  input  logic [$clog2(SLOTS)-1:0]         step_i,
  input  entry_t                           head_i,
  input  logic [$clog2(SLOTS)-1:0]         head_rank_i,
  output entry_t                           tail_o,
  output logic [$clog2(SLOTS)-1:0]         tail_rank_o,
  output logic [$clog2(SLOTS)-1:0]         dec_rank_o,
  output head_stat_t                       stat_o,
  output logic [AppW-1:0]                  found_app_o,
  output logic [$clog2(SLOTS)-1:0]         free_pos_o,
  output logic [$clog2(SLOTS)-1:0]         best_pos_o,
  output logic [$clog2(SLOTS)-1:0]         best_rank_o,
  output logic [$clog2(SLOTS+1)-1:0]       expired_o
);

  localparam int unsigned PosW   = $clog2(SLOTS);
  localparam int unsigned CountW = $clog2(SLOTS+1);

  logic              found_q, free_v_q, best_v_q;
  logic [CountW-1:0] exp_q;
  logic [AppW-1:0]   found_app_q;
  logic [PosW-1:0]   free_pos_q, best_pos_q, best_rank_q;
  logic [AgeW-1:0]   best_age_q;

  logic              h_exp, h_match, h_better;
  logic [CountW-1:0] cnt_m1;

  always_comb begin
    cnt_m1   = count_i - 1'b1;
    h_exp    = ctl_i.prune && head_i.valid && (head_i.age >= ttl_i);
    h_match  = ctl_i.lookup && head_i.valid && !h_exp && !found_q &&
               (head_i.handle == key_i);
    h_better = head_i.valid && !h_exp && !h_match &&
               (!best_v_q || (head_i.age > best_age_q) ||
                ((head_i.age == best_age_q) && (head_rank_i < best_rank_q)));

    tail_o      = head_i;
    tail_rank_o = head_rank_i;
    if (ctl_i.run) begin
      if (h_exp) begin
        tail_o.valid = 1'b0;
      end else if (h_match) begin
        if (ctl_i.replace) begin
          // Rewritten in place as the newest entry; the count is unchanged.
          tail_o      = '{valid: 1'b1, handle: key_i, app: app_i, age: '0};
          tail_rank_o = cnt_m1[PosW-1:0];
        end else begin
          tail_o.valid = 1'b0;
        end
      end
    end

    dec_rank_o     = head_rank_i;
    stat_o.dec_en  = ctl_i.run && (h_exp || h_match);
    stat_o.cnt_dec = ctl_i.run && (h_exp || (h_match && !ctl_i.replace));
    stat_o.found   = found_q;
    stat_o.free_v  = free_v_q;
    stat_o.best_v  = best_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      free_v_q <= 1'b0;
      best_v_q <= 1'b0;
      exp_q    <= '0;
    end else if (start_i) begin
      found_q  <= 1'b0;
      free_v_q <= 1'b0;
      best_v_q <= 1'b0;
      exp_q    <= '0;
    end else if (ctl_i.run) begin
      if (h_match) begin
        found_q <= 1'b1;
      end
      if (!tail_o.valid) begin
        free_v_q <= 1'b1;
      end
      if (h_better) begin
        best_v_q <= 1'b1;
      end
      if (h_exp) begin
        exp_q <= exp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.run) begin
      if (h_match) begin
        found_app_q <= head_i.app;
      end
      // The ring turns a full circle, so the entry at the head in step k
      // ends the pass back in cell k.
      if (!tail_o.valid) begin
        free_pos_q <= step_i;
      end
      if (h_better) begin
        best_pos_q  <= step_i;
        best_rank_q <= head_rank_i;
        best_age_q  <= head_i.age;
      end
    end
  end

  assign found_app_o = found_app_q;
  assign free_pos_o  = free_pos_q;
  assign best_pos_o  = best_pos_q;
  assign best_rank_o = best_rank_q;
  assign expired_o   = exp_q;

endmodule

// ----- sv/pending_handle_table_ttl_unit.sv -----
`timescale 1ns / 1ps
// Top level of the pending handle table with time-to-live and oldest eviction.
// Depends on pht_pkg, pht_cell and pht_head.
//
// The table holds up to SLOTS entries, each a nonzero 64-bit handle, an
// application id, an age in ticks and an insertion rank, in a ring of
// identical cells. Every input transaction yields exactly one result
// transaction. Record (with nonzero handle and id), claim and forget (with a
// nonzero handle) and count turn the ring once: at each step every cell
// hands its entry to its lower neighbor and cell zero feeds the head unit,
// which prunes entries whose age has reached ttl_ticks (all but forget),
// matches the handle (all but count), and remembers a free cell and the
// eviction victim (largest age, earliest insertion on a tie). A record
// that finds no match then writes its new entry straight into the
// remembered free or victim cell; each entry must pass the single shared
// head unit. Reject cases, clear, tick and unused action codes skip the
// ring turn: clear and tick act on every cell together as the input is
// accepted. A new input transaction is accepted only while the sequencer
// is idle; a finished result sits in an output register, so the next input
// can be accepted before the previous result has been taken. The
// configuration register ttl_ticks (reset 60) is written with cfg_we_i and
// must only be changed while the block is idle. Entries need no clearing
// pass after reset: each cell has its own valid flop.
module pending_handle_table_ttl_unit import pht_pkg::*; #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           action_i,
  input  logic [HandleW-1:0]   handle_i,
  input  logic [AppW-1:0]      app_id_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [AppW-1:0]      app_id_out_o,
  output logic [CountOutW-1:0] entry_count_o,
  output logic [CountOutW-1:0] expired_count_o,
  input  logic                 cfg_we_i,
  input  logic [TtlW-1:0]      cfg_wdata_i
);

  localparam int unsigned PosW   = $clog2(SLOTS);
  localparam int unsigned CountW = $clog2(SLOTS+1);

  // Sequencer state and the transaction being worked on.
  state_e             state_q, state_d;
  logic [PosW-1:0]    step_q, step_d;
  action_e            act_q;
  logic [HandleW-1:0] key_q;
  logic [AppW-1:0]    app_q;
  head_ctl_t          hctl_q, hctl_in;
  logic [TtlW-1:0]    ttl_q;
  logic [CountW-1:0]  count_q, count_d;
  status_e            res_status_q, res_status_d;
  logic [AppW-1:0]    res_app_q, res_app_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [2:0]           out_status_q;
  logic [AppW-1:0]      out_app_q;
  logic [CountOutW-1:0] out_count_q, out_exp_q;

  action_e  act_in;
  logic     acc, last_step, key_zero, full;
  logic     run, shift, tick_all, clear_all, load_en, dec_all, cnt_inc, out_load;
  logic [PosW-1:0] load_pos, load_rank, dec_rank;

  // Ring of cells.
  entry_t          cell_e [SLOTS];
  logic [PosW-1:0] cell_r [SLOTS];
  entry_t          nb_e   [SLOTS];
  logic [PosW-1:0] nb_r   [SLOTS];
  cell_ctl_t       cctl   [SLOTS];
  entry_t          ld_e;

  // Head unit.
  head_ctl_t         hctl;
  head_stat_t        hstat;
  entry_t            tail_e;
  logic [PosW-1:0]   tail_r, head_dec_rank, free_pos, best_pos, best_rank;
  logic [AppW-1:0]   found_app;
  logic [CountW-1:0] expired;

  assign act_in    = action_e'(action_i);
  assign acc       = in_valid_i && in_ready_o;
  assign last_step = (step_q == PosW'(SLOTS - 1));
  assign key_zero  = (handle_i == '0);
  assign full      = (count_q == CountW'(SLOTS));

  always_comb begin
    hctl_in.run     = 1'b0;
    hctl_in.prune   = (act_in == ACT_RECORD) || (act_in == ACT_CLAIM) ||
                      (act_in == ACT_COUNT);
    hctl_in.lookup  = (act_in == ACT_RECORD) || (act_in == ACT_CLAIM) ||
                      (act_in == ACT_FORGET);
    hctl_in.replace = (act_in == ACT_RECORD);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (act_in)
            ACT_RECORD: begin
              state_d = (key_zero || (app_id_i == '0)) ? S_DONE : S_SCAN;
            end
            ACT_CLAIM, ACT_FORGET: begin
              state_d = key_zero ? S_DONE : S_SCAN;
            end
            ACT_COUNT: begin
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (last_step) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o   = 1'b0;
    run          = 1'b0;
    shift        = 1'b0;
    tick_all     = 1'b0;
    clear_all    = 1'b0;
    load_en      = 1'b0;
    load_pos     = free_pos;
    load_rank    = count_q[PosW-1:0];
    dec_all      = 1'b0;
    dec_rank     = head_dec_rank;
    cnt_inc      = 1'b0;
    out_load     = 1'b0;
    res_status_d = res_status_q;
    res_app_d    = res_app_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (acc) begin
          res_app_d = '0;
          tick_all  = (act_in == ACT_TICK);
          clear_all = (act_in == ACT_CLEAR);
          if (act_in == ACT_RECORD) begin
            res_status_d = (key_zero || (app_id_i == '0)) ? ST_REJECTED : ST_DONE;
          end else if (act_in == ACT_CLAIM) begin
            res_status_d = ST_NOTFOUND;
          end else begin
            res_status_d = ST_DONE;
          end
        end
      end
      S_SCAN: begin
        run     = 1'b1;
        shift   = 1'b1;
        dec_all = hstat.dec_en;
      end
      S_DECIDE: begin
        if (act_q == ACT_RECORD) begin
          if (hstat.found) begin
            res_status_d = ST_REPLACED;
          end else if (full) begin
            // Overwrite the victim as the newest entry and close its rank gap.
            res_status_d = ST_EVICTED;
            load_en      = 1'b1;
            load_pos     = best_pos;
            load_rank    = PosW'(SLOTS - 1);
            dec_all      = 1'b1;
            dec_rank     = best_rank;
          end else begin
            res_status_d = ST_NEW;
            load_en      = 1'b1;
            cnt_inc      = 1'b1;
          end
        end else if ((act_q == ACT_CLAIM) && hstat.found) begin
          res_status_d = ST_CLAIMED;
          res_app_d    = found_app;
        end
      end
      S_DONE: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    step_d = (state_q == S_SCAN && !last_step) ? step_q + 1'b1 : '0;
    if (clear_all) begin
      count_d = '0;
    end else if (hstat.cnt_dec) begin
      count_d = count_q - 1'b1;
    end else if (cnt_inc) begin
      count_d = count_q + 1'b1;
    end else begin
      count_d = count_q;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      count_q      <= '0;
      ttl_q        <= TtlReset;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_DONE;
      act_q        <= ACT_COUNT;
      hctl_q       <= '0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      res_status_q <= res_status_d;
      if (cfg_we_i) begin
        ttl_q <= cfg_wdata_i;
      end
      if (acc) begin
        act_q  <= act_in;
        hctl_q <= hctl_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_app_q <= res_app_d;
    if (acc) begin
      key_q <= handle_i;
      app_q <= app_id_i;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_app_q    <= res_app_q;
      out_count_q  <= CountOutW'(count_q);
      out_exp_q    <= CountOutW'(expired);
    end
  end

  // Per-cell controls. The tail cell takes the head unit's output during a
  // turn, which already carries its final rank, so it sees no decrement then.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cctl[i].shift  = shift;
      cctl[i].load   = load_en && (load_pos == PosW'(i));
      cctl[i].tick   = tick_all;
      cctl[i].clear  = clear_all;
      cctl[i].dec_en = dec_all && !(shift && (i == SLOTS - 1));
    end
  end

  assign ld_e = '{valid: 1'b1, handle: key_q, app: app_q, age: '0};

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    if (g == SLOTS - 1) begin : g_tail
      assign nb_e[g] = tail_e;
      assign nb_r[g] = tail_r;
    end else begin : g_body
      assign nb_e[g] = cell_e[g+1];
      assign nb_r[g] = cell_r[g+1];
    end

    pht_cell #(
      .RankW(PosW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (cctl[g]),
      .nb_i       (nb_e[g]),
      .nb_rank_i  (nb_r[g]),
      .ld_i       (ld_e),
      .ld_rank_i  (load_rank),
      .dec_rank_i (dec_rank),
      .entry_o    (cell_e[g]),
      .rank_o     (cell_r[g])
    );
  end

  always_comb begin
    hctl     = hctl_q;
    hctl.run = run;
  end

  pht_head #(
    .SLOTS(SLOTS)
  ) u_head (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (acc),
    .ctl_i       (hctl),
    .key_i       (key_q),
    .app_i       (app_q),
    .ttl_i       (ttl_q),
    .count_i     (count_q),
    .step_i      (step_q),
    .head_i      (cell_e[0]),
    .head_rank_i (cell_r[0]),
    .tail_o      (tail_e),
    .tail_rank_o (tail_r),
    .dec_rank_o  (head_dec_rank),
    .stat_o      (hstat),
    .found_app_o (found_app),
    .free_pos_o  (free_pos),
    .best_pos_o  (best_pos),
    .best_rank_o (best_rank),
    .expired_o   (expired)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign app_id_out_o    = out_app_q;
  assign entry_count_o   = out_count_q;
  assign expired_count_o = out_exp_q;

  // The entry count never goes past the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(SLOTS))
    else $error("entry count exceeds table size");

  // The step counter only runs while the ring turns.
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SCAN) |-> (step_q == '0))
    else $error("step counter moved outside a ring turn");

  // The head unit never removes an entry from an empty table.
  a_drop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hstat.cnt_dec |-> (count_q != '0))
    else $error("entry dropped while count is zero");

  // A result only appears after the sequencer has finished an item.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

  // A record into a full table always has a victim to evict.
  a_evict_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && act_q == ACT_RECORD && !hstat.found && full)
      |-> hstat.best_v)
    else $error("eviction without a victim");

endmodule

// ----- verif/pht_reply_checker.sv -----
`timescale 1ns / 1ps
// Reply checker for pending_handle_table_ttl_unit: tracks the table and the TTL, predicts
// one reply per request transaction and compares it with what the block returns.
// Depends on pht_pkg.
module pht_reply_checker import pht_pkg::*; #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  input  logic [2:0]           action_i,
  input  logic [HandleW-1:0]   handle_i,
  input  logic [AppW-1:0]      app_id_i,
  input  logic                 rsp_valid_i,
  input  logic                 rsp_ready_i,
  input  logic [2:0]           status_i,
  input  logic [AppW-1:0]      app_id_out_i,
  input  logic [CountOutW-1:0] entry_count_i,
  input  logic [CountOutW-1:0] expired_count_i,
  input  logic                 cfg_we_i,
  input  logic [TtlW-1:0]      cfg_wdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [2:0]           status;
    logic [AppW-1:0]      app;
    logic [CountOutW-1:0] held;
    logic [CountOutW-1:0] expired;
  } reply_t;

  bit                 slot_used   [SLOTS];
  logic [HandleW-1:0] slot_handle [SLOTS];
  logic [AppW-1:0]    slot_app    [SLOTS];
  logic [AgeW-1:0]    slot_age    [SLOTS];
  int unsigned        slot_rank   [SLOTS];
  logic [TtlW-1:0]    ttl_q;
  reply_t             awaited_replies [$];

  function automatic int unsigned occupancy();
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < SLOTS; i++) if (slot_used[i]) n++;
    return n;
  endfunction

  // Freeing a slot closes the gap in the insertion ranks above it.
  function automatic void remove_slot(input int unsigned s);
    int unsigned r;
    r = slot_rank[s];
    slot_used[s] = 1'b0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_rank[i] > r) slot_rank[i]--;
    end
  endfunction

  function automatic int unsigned prune_aged();
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_age[i] >= ttl_q) begin
        remove_slot(i);
        n++;
      end
    end
    return n;
  endfunction

  function automatic int unsigned find_handle(input logic [HandleW-1:0] key);
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_handle[i] == key) return i;
    end
    return SLOTS;
  endfunction

  // Largest age wins; on equal ages the lowest rank (recorded earliest) wins.
  function automatic int unsigned oldest_victim();
    int unsigned best;
    best = SLOTS;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && (best == SLOTS || slot_age[i] > slot_age[best] ||
          (slot_age[i] == slot_age[best] && slot_rank[i] < slot_rank[best]))) best = i;
    end
    return best;
  endfunction

  function automatic reply_t predict_reply(input logic [2:0] act,
                                           input logic [HandleW-1:0] key,
                                           input logic [AppW-1:0] app);
    reply_t      r;
    int unsigned s;
    int unsigned gone;
    r.status = ST_DONE;
    r.app = '0;
    gone = 0;
    case (act)
      ACT_RECORD: begin
        if (key == '0 || app == '0) begin
          r.status = ST_REJECTED;
        end else begin
          gone = prune_aged();
          s = find_handle(key);
          if (s < SLOTS) begin
            remove_slot(s);
            r.status = ST_REPLACED;
          end else if (occupancy() >= SLOTS) begin
            s = oldest_victim();
            remove_slot(s);
            r.status = ST_EVICTED;
          end else begin
            s = 0;
            while (slot_used[s]) s++;
            r.status = ST_NEW;
          end
          slot_rank[s] = occupancy();
          slot_used[s] = 1'b1;
          slot_handle[s] = key;
          slot_app[s] = app;
          slot_age[s] = '0;
        end
      end
      ACT_CLAIM: begin
        r.status = ST_NOTFOUND;
        if (key != '0) begin
          gone = prune_aged();
          s = find_handle(key);
          if (s < SLOTS) begin
            r.app = slot_app[s];
            remove_slot(s);
            r.status = ST_CLAIMED;
          end
        end
      end
      ACT_FORGET: begin
        if (key != '0) begin
          s = find_handle(key);
          if (s < SLOTS) remove_slot(s);
        end
      end
      ACT_CLEAR: begin
        for (int unsigned i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      end
      ACT_COUNT: begin
        gone = prune_aged();
      end
      ACT_TICK: begin
        for (int unsigned i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && slot_age[i] != '1) slot_age[i]++;
        end
      end
      default: begin
      end
    endcase
    r.held = CountOutW'(occupancy());
    r.expired = CountOutW'(gone);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      ttl_q = TtlReset;
      awaited_replies.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) ttl_q = cfg_wdata_i;
      // A reply can never belong to a request taken on the same edge, so replies go first.
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_replies.size() == 0) begin
          fail_count_o += 1;
          if (fail_count_o <= 10) begin
            $display("%0t: reply with no request outstanding: status %0d app %h count %0d",
                     $realtime, status_i, app_id_out_i, entry_count_i);
          end
        end else begin
          want = awaited_replies.pop_front();
          if (status_i !== want.status || app_id_out_i !== want.app ||
              entry_count_i !== want.held || expired_count_i !== want.expired) begin
            fail_count_o += 1;
            if (fail_count_o <= 10) begin
              $display("%0t: reply mismatch (expected/actual): status %0d/%0d app %h/%h",
                       $realtime, want.status, status_i, want.app, app_id_out_i);
              $display("    entry count %0d/%0d expired %0d/%0d",
                       want.held, entry_count_i, want.expired, expired_count_i);
            end
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        awaited_replies.push_back(predict_reply(action_i, handle_i, app_id_i));
      end
      pending_o = awaited_replies.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Regression top for pending_handle_table_ttl_unit: clock, reset, request and reply traffic,
// TTL writes, watchdog and the verdict. Depends on pht_pkg, the block and pht_reply_checker.
module testbench;
  import pht_pkg::*;

  localparam int unsigned Slots       = 32;
  localparam int unsigned PoolSize    = 48;
  // Longest quiet stretch in a correct run is the long reply hold-off; the limit leaves
  // a wide margin above it.
  localparam int unsigned StuckLimit  = 4000;
  localparam int unsigned HoldCycles  = 400;
  // The drain wait covers a full ring turn with room.
  localparam int unsigned DrainCycles = Slots + 8;
  // Action codes that the block treats as no-ops.
  localparam logic [2:0]  ActSpare6   = 3'd6;
  localparam logic [2:0]  ActSpare7   = 3'd7;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [2:0]           action_i;
  logic [HandleW-1:0]   handle_i;
  logic [AppW-1:0]      app_id_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [2:0]           status_o;
  logic [AppW-1:0]      app_id_out_o;
  logic [CountOutW-1:0] entry_count_o;
  logic [CountOutW-1:0] expired_count_o;
  logic                 cfg_we_i;
  logic [TtlW-1:0]      cfg_wdata_i;

  int unsigned          mismatch_total;
  int unsigned          replies_pending;

  // Traffic shaping, set by the stimulus process and read by the reply-side process.
  int unsigned          src_gap_pct;
  int unsigned          sink_gap_pct;
  bit                   quiet_tail;
  bit                   hold_request;

  // Handles drawn for the random part. A pool larger than the table lets the table fill up
  // and evict, while repeated draws give replacements, claim hits and forget hits.
  logic [HandleW-1:0]   handle_pool [PoolSize];
  int unsigned          pool_n;
  // Weights for record, claim, forget, clear, count, tick and the unused codes.
  int unsigned          mix_w [7];

  int unsigned          stuck_cycles;

  pending_handle_table_ttl_unit #(
    .SLOTS(Slots)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .handle_i       (handle_i),
    .app_id_i       (app_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .app_id_out_o   (app_id_out_o),
    .entry_count_o  (entry_count_o),
    .expired_count_o(expired_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  pht_reply_checker #(
    .SLOTS(Slots)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (in_valid_i),
    .req_ready_i    (in_ready_o),
    .action_i       (action_i),
    .handle_i       (handle_i),
    .app_id_i       (app_id_i),
    .rsp_valid_i    (out_valid_o),
    .rsp_ready_i    (out_ready_i),
    .status_i       (status_o),
    .app_id_out_i   (app_id_out_o),
    .entry_count_i  (entry_count_o),
    .expired_count_i(expired_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_count_o   (mismatch_total),
    .pending_o      (replies_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offers one request transaction and returns at the edge where it is taken. Valid stays
  // high afterwards unless a gap follows, so a back-to-back caller simply overwrites the
  // payload in the same time step. Callers that stop sending must lower valid themselves.
  task automatic offer(input logic [2:0] act, input logic [HandleW-1:0] h,
                       input logic [AppW-1:0] a);
    in_valid_i <= 1'b1;
    action_i   <= act;
    handle_i   <= h;
    app_id_i   <= a;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // The TTL may only change while the block is idle. Every request yields a reply, so
  // once nothing is pending the sequencer is done; the extra cycles are a safety margin.
  // This is also where the sender pauses until every reply has come back. The first edge
  // lets the checker log the request taken just before.
  task automatic write_ttl(input logic [TtlW-1:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (replies_pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random traffic with the current action mix and handle pool. The idle rates are drawn
  // again every 32 transactions so that busy stretches alternate with bursty ones.
  task automatic run_phase(input int unsigned n_items);
    int unsigned        total;
    int unsigned        pick;
    int unsigned        k;
    int unsigned        roll;
    logic [2:0]         act;
    logic [HandleW-1:0] h;
    logic [AppW-1:0]    a;
    total = 0;
    for (int unsigned j = 0; j < 7; j++) total += mix_w[j];
    for (int unsigned n = 0; n < n_items; n++) begin
      if (n % 32 == 0) begin
        roll = $urandom_range(0, 2);
        src_gap_pct  = quiet_tail ? 0 : (roll == 0 ? 0 : (roll == 1 ? 15 : 40));
        roll = $urandom_range(0, 2);
        sink_gap_pct = quiet_tail ? 0 : (roll == 0 ? 0 : (roll == 1 ? 15 : 40));
      end
      pick = $urandom_range(0, total - 1);
      k = 0;
      while (pick >= mix_w[k]) begin
        pick -= mix_w[k];
        k++;
      end
      case (k)
        0:       act = ACT_RECORD;
        1:       act = ACT_CLAIM;
        2:       act = ACT_FORGET;
        3:       act = ACT_CLEAR;
        4:       act = ACT_COUNT;
        5:       act = ACT_TICK;
        default: act = $urandom_range(0, 1) ? ActSpare7 : ActSpare6;
      endcase
      // Mostly pool handles; a few zero handles and a few fresh random ones that miss.
      roll = $urandom_range(0, 99);
      if (roll < 4)      h = '0;
      else if (roll < 9) h = {$urandom, $urandom};
      else               h = handle_pool[$urandom_range(0, pool_n - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 4)      a = '0;
      else if (roll < 8) a = '1;
      else               a = $urandom;
      offer(act, h, a);
    end
  endtask

  // Reply side: random stall bursts, plus one long hold-off on request. During the
  // hold-off the sender keeps offering, so the block parks a finished reply in its
  // output register, takes one more request and then drops its ready.
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left  = 0;
    stall_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (sink_gap_pct != 0 && $urandom_range(0, 99) < sink_gap_pct / 4) begin
        stall_left = $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: any transaction on either channel, or a TTL write, counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("pending_handle_table_ttl_unit regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i  <= 1'b0;
    action_i    <= ACT_COUNT;
    handle_i    <= '0;
    app_id_i    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    quiet_tail   = 1'b0;
    hold_request = 1'b0;
    src_gap_pct  = 25;
    sink_gap_pct = 25;

    // Edge handles first, the rest random and nonzero.
    handle_pool[0] = '1;
    handle_pool[1] = 64'h1;
    handle_pool[2] = 64'h8000_0000_0000_0000;
    for (int unsigned i = 3; i < PoolSize; i++) begin
      handle_pool[i] = {$urandom, $urandom};
      if (handle_pool[i] == '0) handle_pool[i] = 64'h2;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset TTL of 60. Field extremes, rejects, replacement,
    // claim and forget hits and misses, zero-handle claim and forget (no prune),
    // tick, count, clear and the two unused action codes.
    offer(ACT_RECORD, '1, '1);
    offer(ACT_RECORD, 64'h1, 32'h1);
    offer(ACT_RECORD, '0, 32'h5);
    offer(ACT_RECORD, 64'h5, '0);
    offer(ACT_RECORD, '0, '0);
    offer(ACT_RECORD, '1, 32'h1234_5678);
    offer(ACT_CLAIM, '0, '0);
    offer(ACT_CLAIM, 64'h5555_5555_5555_5555, '0);
    offer(ACT_CLAIM, '1, '0);
    offer(ACT_FORGET, '0, '0);
    offer(ACT_FORGET, 64'hDEAD_BEEF, '0);
    offer(ACT_FORGET, 64'h1, '0);
    offer(ACT_RECORD, 64'h8000_0000_0000_0000, 32'h8000_0000);
    offer(ACT_TICK, '0, '0);
    offer(ACT_COUNT, '0, '0);
    offer(ActSpare6, '1, '1);
    offer(ActSpare7, '1, '1);
    offer(ACT_CLEAR, '0, '0);
    offer(ACT_COUNT, '0, '0);

    // Smallest nonzero TTL: one tick expires an entry, seen both by count and by a claim that
    // then misses after its prune.
    write_ttl(32'd1);
    offer(ACT_RECORD, 64'hA5A5_A5A5_A5A5_A5A5, 32'h3);
    offer(ACT_TICK, '0, '0);
    offer(ACT_COUNT, '0, '0);
    offer(ACT_RECORD, 64'h5A5A_5A5A_5A5A_5A5A, 32'h4);
    offer(ACT_TICK, '0, '0);
    offer(ACT_CLAIM, 64'h5A5A_5A5A_5A5A_5A5A, '0);

    // Largest TTL, record heavy: the table fills and evicts by age and rank. The long
    // reply hold-off happens here while the sender keeps going.
    write_ttl('1);
    mix_w  = '{60, 12, 6, 1, 6, 12, 3};
    pool_n = PoolSize;
    hold_request = 1'b1;
    run_phase(260);

    // Short TTL with plenty of ticks, so entries expire during record, claim and count.
    write_ttl(32'd3);
    mix_w  = '{40, 15, 5, 1, 10, 25, 4};
    pool_n = 40;
    run_phase(220);

    write_ttl(32'd1);
    mix_w  = '{45, 20, 5, 1, 10, 15, 4};
    pool_n = 24;
    run_phase(140);

    write_ttl($urandom_range(2, 40));
    mix_w  = '{50, 15, 5, 1, 8, 18, 3};
    pool_n = PoolSize;
    run_phase(100);
    write_ttl($urandom_range(2, 40));
    run_phase(100);

    // A TTL of zero makes every held entry expire at the next prune.
    write_ttl('0);
    mix_w  = '{40, 20, 5, 2, 15, 15, 3};
    pool_n = 40;
    run_phase(60);

    // Last part at the default TTL without any idling on either side.
    write_ttl(TtlReset);
    quiet_tail   = 1'b1;
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    mix_w  = '{55, 15, 5, 1, 8, 14, 2};
    pool_n = PoolSize;
    run_phase(250);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (replies_pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_total == 0 && replies_pending == 0) begin
      $display("pending_handle_table_ttl_unit regression: pass");
    end else begin
      $display("pending_handle_table_ttl_unit regression: fail");
    end
    $finish;
  end

endmodule
